// File: design/lpe_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the LSB payload extractor.
// No dependencies; every other design file imports this package.
package lpe_pkg;

   localparam int BYTE_W    = 8;
   localparam int BPC_W     = 4;
   localparam int MLEN_W    = 4;
   localparam int MAGIC_W   = 64;
   localparam int CSR_IDX_W = 2;

   typedef logic [BYTE_W-1:0]    byte_type;
   typedef logic [BPC_W-1:0]     bpc_type;
   typedef logic [MLEN_W-1:0]    mlen_type;
   typedef logic [MAGIC_W-1:0]   magic_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BITS_PER_CHANNEL = 2'd0,
      CSR_MAGIC_LENGTH     = 2'd1,
      CSR_MAGIC_BYTES      = 2'd2
   } csr_reg_type;

   // completed byte handed from the bit packer to the window
   typedef struct packed {
      logic     valid;
      byte_type data;
   } byte_evt_type;

   // result of one step of the window
   typedef struct packed {
      logic     produce;
      byte_type payload_byte;
      logic     byte_valid;
      logic     end_found;
   } result_type;

endpackage

// File: design/lpe_ifs.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the LSB payload extractor.
// Depends on lpe_pkg.
interface lpe_req_if import lpe_pkg::*; ();
   logic     valid;
   logic     ready;
   byte_type channel_value;
   modport source (output valid, output channel_value, input ready);
   modport sink   (input valid, input channel_value, output ready);
endinterface

interface lpe_rsp_if import lpe_pkg::*; ();
   logic     valid;
   logic     ready;
   byte_type payload_byte;
   logic     byte_valid;
   logic     end_found;
   modport source (output valid, output payload_byte, output byte_valid,
                   output end_found, input ready);
   modport sink   (input valid, input payload_byte, input byte_valid,
                   input end_found, output ready);
endinterface

interface lpe_csr_if import lpe_pkg::*; ();
   logic        valid;
   logic        ready;
   csr_idx_type index;
   magic_type   data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: design/lsb_payload_extractor.sv
`timescale 1ns / 1ps
// LSB payload extractor top level. Depends on lpe_pkg, lpe_ifs, lpe_bit_packer, lpe_magic_window.
// Path: an accepted beat is held in the input register, then passes through the packing
// and window logic into the result register, where its result (if any) shows.
// Throughput: one beat per cycle; the result register stalls the input only while held.
// Reset: synchronous; clears partial byte, window fill, end flag and restores registers.
module lsb_payload_extractor import lpe_pkg::*; #(
   parameter int MAX_MAGIC_BYTES = 8
) (
   input logic        clock,
   input logic        reset,
   lpe_req_if.sink    req_ch,
   lpe_rsp_if.source  rsp_ch,
   lpe_csr_if.sink    csr_ch
);

   bpc_type      bpc_ff;
   mlen_type     mlen_ff;
   magic_type    magic_ff;

   logic         s1_valid_ff, s1_valid_in;
   byte_type     s1_value_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   byte_type     rsp_byte_ff;
   logic         rsp_bvalid_ff;
   logic         rsp_end_ff;

   logic         out_free;
   logic         fire;
   logic         finished;
   byte_evt_type byte_evt;
   result_type   result;

   // configuration writes
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         bpc_ff   <= bpc_type'(1);
         mlen_ff  <= mlen_type'(4);
         magic_ff <= '0;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_BITS_PER_CHANNEL: bpc_ff   <= csr_ch.data[BPC_W-1:0];
            CSR_MAGIC_LENGTH:     mlen_ff  <= csr_ch.data[MLEN_W-1:0];
            CSR_MAGIC_BYTES:      magic_ff <= csr_ch.data;
            default: ;
         endcase
      end
   end

   // input register
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign fire         = s1_valid_ff && out_free;
   assign req_ch.ready = !s1_valid_ff || out_free;
   assign s1_valid_in  = req_ch.valid || (s1_valid_ff && !out_free);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         s1_value_ff <= req_ch.channel_value;
      end
   end

   lpe_bit_packer u_packer (
      .clock            (clock),
      .reset            (reset),
      .step             (fire && !finished),
      .channel_value    (s1_value_ff),
      .bits_per_channel (bpc_ff),
      .byte_evt         (byte_evt)
   );

   lpe_magic_window #(
      .DEPTH (MAX_MAGIC_BYTES)
   ) u_window (
      .clock        (clock),
      .reset        (reset),
      .byte_evt     (byte_evt),
      .magic_length (mlen_ff),
      .magic_bytes  (magic_ff),
      .result       (result),
      .finished     (finished)
   );

   // result register
   assign rsp_valid_in = fire && result.produce;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && rsp_valid_in) begin
         rsp_byte_ff   <= result.payload_byte;
         rsp_bvalid_ff <= result.byte_valid;
         rsp_end_ff    <= result.end_found;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.payload_byte = rsp_byte_ff;
   assign rsp_ch.byte_valid   = rsp_bvalid_ff;
   assign rsp_ch.end_found    = rsp_end_ff;

   // a beat always carries a byte or the end mark
   a_rsp_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_bvalid_ff || rsp_end_ff))
      else $error("result beat with neither byte nor end mark");

   // no released byte means a zero payload
   a_rsp_zero_byte: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_bvalid_ff) |-> (rsp_byte_ff == '0))
      else $error("payload byte nonzero without byte_valid");

   // end flag stays set until reset
   a_finished_sticky: assert property (@(posedge clock) disable iff (reset)
      finished |=> finished)
      else $error("end flag cleared without reset");

   // after the end, no new result enters the result register
   a_no_rsp_after_end: assert property (@(posedge clock) disable iff (reset)
      (finished && !rsp_valid_ff) |=> !rsp_valid_ff)
      else $error("result produced after end of payload");

endmodule

// File: design/lpe_bit_packer.sv
`timescale 1ns / 1ps
// Bit packer: appends the low bits of each channel value to a partial byte.
// Depends on lpe_pkg.
module lpe_bit_packer import lpe_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  byte_type     channel_value,
   input  bpc_type      bits_per_channel,
   output byte_evt_type byte_evt
);

   byte_type    partial_ff, partial_in;
   logic [2:0]  count_ff, count_in;
   logic [3:0]  nb;
   logic [3:0]  total;
   logic [2:0]  sh;
   logic [15:0] combined;

   always_comb begin
      nb       = (bits_per_channel > 4'd8) ? 4'd8 : bits_per_channel;
      total    = {1'b0, count_ff} + nb;
      combined = ({8'b0, partial_ff} << nb) | ({8'b0, channel_value} & ~(16'hFFFF << nb));
      sh       = 3'(total - 4'd8);
      byte_evt.valid = 1'b0;
      byte_evt.data  = '0;
      partial_in = partial_ff;
      count_in   = count_ff;
      if (step) begin
         if (total >= 4'd8) begin
            // byte complete: top eight bits leave, the rest start a new byte
            byte_evt.valid = 1'b1;
            byte_evt.data  = 8'(combined >> sh);
            partial_in     = 8'(combined & ~(16'hFFFF << sh));
            count_in       = sh;
         end else begin
            partial_in = combined[7:0];
            count_in   = total[2:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff <= '0;
         count_ff   <= '0;
      end else begin
         partial_ff <= partial_in;
         count_ff   <= count_in;
      end
   end

endmodule

// File: design/lpe_magic_window.sv
`timescale 1ns / 1ps
// Window of the newest bytes: releases the oldest, detects the end marker.
// Depends on lpe_pkg.
module lpe_magic_window import lpe_pkg::*; #(
   parameter int DEPTH = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  byte_evt_type byte_evt,
   input  mlen_type     magic_length,
   input  magic_type    magic_bytes,
   output result_type   result,
   output logic         finished
);

   localparam int FILL_W = $clog2(DEPTH + 1);
   localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // newest byte at index 0
   byte_type            hist_ff [DEPTH];
   byte_type            hist_in [DEPTH];
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic                finished_ff, finished_in;

   byte_type            magic_arr [DEPTH];
   byte_type            recent    [DEPTH];
   logic [FILL_W-1:0]   len;
   logic [FILL_W:0]     fill_plus;
   logic [FILL_W-1:0]   n_new;
   logic [FILL_W-1:0]   oldest_idx;
   logic [FILL_W:0]     mi;
   logic                released;
   logic                match;
   byte_type            rel_byte;

   always_comb begin
      for (int k = 0; k < DEPTH; k++) begin
         magic_arr[k] = magic_bytes[8*k +: 8];
      end
      len        = (MLEN_W'(DEPTH) < magic_length) ? FILL_W'(DEPTH) : FILL_W'(magic_length);
      fill_plus  = (FILL_W+1)'(fill_ff) + (FILL_W+1)'(1);
      released   = fill_plus > (FILL_W+1)'(len);
      n_new      = released ? fill_ff : FILL_W'(fill_plus);
      oldest_idx = fill_ff - FILL_W'(1);
      rel_byte   = (fill_ff == '0) ? byte_evt.data : hist_ff[oldest_idx[IDX_W-1:0]];

      // compare the newest len bytes against the marker, oldest marker byte first
      match = (n_new >= len);
      for (int j = 0; j < DEPTH; j++) begin
         recent[j] = (j == 0) ? byte_evt.data : hist_ff[(j == 0) ? 0 : j - 1];
         mi        = (FILL_W+1)'(len) - (FILL_W+1)'(j) - (FILL_W+1)'(1);
         if ((FILL_W+1)'(j) < (FILL_W+1)'(len)) begin
            if (recent[j] != magic_arr[mi[IDX_W-1:0]]) begin
               match = 1'b0;
            end
         end
      end

      for (int k = 0; k < DEPTH; k++) begin
         hist_in[k] = hist_ff[k];
      end
      fill_in     = fill_ff;
      finished_in = finished_ff;
      if (byte_evt.valid) begin
         hist_in[0] = byte_evt.data;
         for (int k = 1; k < DEPTH; k++) begin
            hist_in[k] = hist_ff[k-1];
         end
         fill_in     = n_new;
         finished_in = finished_ff | match;
      end

      result.produce      = byte_evt.valid && (released || match);
      result.payload_byte = released ? rel_byte : '0;
      result.byte_valid   = released;
      result.end_found    = match;
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < DEPTH; k++) begin
         hist_ff[k] <= hist_in[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff     <= '0;
         finished_ff <= 1'b0;
      end else begin
         fill_ff     <= fill_in;
         finished_ff <= finished_in;
      end
   end

   assign finished = finished_ff;

endmodule
